/* rtl/gbf_pkg.sv */
// shared types and constants for the 1bpp glyph blitter
// no dependencies; used by gbf_store, gbf_engine, glyph_blit_1bpp_framebuffer and the testbench
`timescale 1ns / 1ps

package gbf_pkg;

  localparam int FRAME_WIDTH_DEF  = 256;
  localparam int FRAME_HEIGHT_DEF = 64;
  localparam int GLYPH_SIZE       = 8;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  // item kinds
  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pos_x;
    logic [5:0]  pos_y;
    logic [63:0] glyph_rows;
    logic        invert;
    logic [10:0] read_index;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       clipped;
  } result_t;

  // frame store port command
  typedef struct packed {
    logic en;
    logic we;
  } mem_cmd_t;

endpackage

/* rtl/gbf_store.sv */
// single-port frame store, one byte per entry, registered read data
// uses gbf_pkg for the port command struct
`timescale 1ns / 1ps

module gbf_store #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  gbf_pkg::mem_cmd_t cmd,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/gbf_engine.sv */
// item sequencer: clearing sweep, glyph read-modify-write, byte reads
// uses gbf_pkg; drives the port of gbf_store
`timescale 1ns / 1ps

module gbf_engine #(
  parameter int FRAME_WIDTH  = 256,
  parameter int FRAME_HEIGHT = 64,
  parameter int DEPTH        = (FRAME_WIDTH / 8) * FRAME_HEIGHT,
  parameter int ADDR_W       = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gbf_pkg::item_t     item,
  output logic               res_valid,
  input  logic               out_free,
  output gbf_pkg::result_t   res,
  output gbf_pkg::mem_cmd_t  mem_cmd,
  output logic [ADDR_W-1:0]  mem_addr,
  output logic [7:0]         mem_wdata,
  input  logic [7:0]         mem_rdata
);

  import gbf_pkg::*;

  localparam int ROW_BYTES = FRAME_WIDTH / 8;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_A, S_WR_A, S_RD_B, S_WR_B, S_READ, S_READ_CAP, S_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_b;
  logic [2:0]        row;
  logic [2:0]        shift;
  logic [63:0]       glyph;
  logic              invert;
  logic              clear_item;

  logic              accept;
  logic              clip;
  logic              read_ok;
  logic [ADDR_W-1:0] draw_addr;
  logic [7:0]        cur_row;
  logic [15:0]       wide;
  logic [15:0]       mask;

  assign accept  = in_valid && in_ready;
  assign clip    = (32'(item.pos_x) + 32'(GLYPH_SIZE) >= 32'(FRAME_WIDTH)) ||
                   (32'(item.pos_y) + 32'(GLYPH_SIZE) >= 32'(FRAME_HEIGHT));
  assign read_ok = 32'(item.read_index) < 32'(DEPTH);
  assign draw_addr = ADDR_W'(32'(item.pos_y) * 32'(ROW_BYTES) + 32'(item.pos_x >> 3));

  // current row, shifted across the two bytes it may touch
  assign cur_row = glyph[63:56] ^ {8{invert}};
  assign wide    = {cur_row, 8'h00} >> shift;
  assign mask    = {BYTE_MASK, 8'h00} >> shift;
  assign addr_b  = addr + ADDR_W'(1);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    mem_cmd   = '0;
    mem_addr  = addr;
    mem_wdata = 8'h00;
    unique case (state)
      S_CLEAR: begin
        mem_cmd = '{en: 1'b1, we: 1'b1};
      end
      S_RD_A, S_READ: begin
        mem_cmd = '{en: 1'b1, we: 1'b0};
      end
      S_WR_A: begin
        mem_cmd   = '{en: 1'b1, we: 1'b1};
        mem_wdata = (mem_rdata & ~mask[15:8]) | wide[15:8];
      end
      S_RD_B: begin
        mem_cmd  = '{en: 1'b1, we: 1'b0};
        mem_addr = addr_b;
      end
      S_WR_B: begin
        mem_cmd   = '{en: 1'b1, we: 1'b1};
        mem_addr  = addr_b;
        mem_wdata = (mem_rdata & ~mask[7:0]) | wide[7:0];
      end
      default: begin
        mem_cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      clear_item <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          addr <= addr + ADDR_W'(1);
          if (addr == ADDR_W'(DEPTH - 1)) begin
            state <= clear_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            // clipped only for a draw that reaches the last column or row
            res        <= '{read_data: 8'h00,
                            clipped: (item.kind == KIND_DRAW) && clip};
            glyph      <= item.glyph_rows;
            invert     <= item.invert;
            shift      <= item.pos_x[2:0];
            row        <= '0;
            clear_item <= (item.kind == KIND_CLEAR);
            case (item.kind)
              KIND_DRAW: begin
                if (clip) begin
                  state <= S_DONE;
                end else begin
                  addr  <= draw_addr;
                  state <= S_RD_A;
                end
              end
              KIND_CLEAR: begin
                addr  <= '0;
                state <= S_CLEAR;
              end
              KIND_READ: begin
                addr  <= ADDR_W'(item.read_index);
                state <= read_ok ? S_READ : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD_A: begin
          state <= S_WR_A;
        end
        S_WR_A, S_WR_B: begin
          if (state == S_WR_A && shift != 3'd0) begin
            state <= S_RD_B;
          end else begin
            glyph <= glyph << 8;
            row   <= row + 3'd1;
            addr  <= addr + ADDR_W'(ROW_BYTES);
            state <= (row == 3'(GLYPH_SIZE - 1)) ? S_DONE : S_RD_A;
          end
        end
        S_RD_B: begin
          state <= S_WR_B;
        end
        S_READ: begin
          state <= S_READ_CAP;
        end
        S_READ_CAP: begin
          res.read_data <= mem_rdata;
          state         <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/glyph_blit_1bpp_framebuffer.sv */
// top level of the 1bpp glyph blitter: stream ports, result register
// depends on gbf_pkg, gbf_store and gbf_engine
`timescale 1ns / 1ps

// Blits 8x8 one-bit glyphs into a FRAME_WIDTH x FRAME_HEIGHT frame store held
// as bytes (leftmost pixel in the MSB) in a single-port synchronous RAM, and
// answers every input transaction with exactly one output transaction. Each
// glyph row is a read-modify-write of one byte, or of two bytes when pos_x is
// not a multiple of eight, all through the single RAM port. A clear sweeps the
// store one byte a cycle, and after reset the same sweep runs with s_tready
// low. The finished result waits in an output register, so the next
// transaction is taken while the previous result is still unclaimed.
module glyph_blit_1bpp_framebuffer #(
  parameter int FRAME_WIDTH  = gbf_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = gbf_pkg::FRAME_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // pos_x[7:0], pos_y[13:8], glyph_rows[77:14],
                                 // invert[78], read_index[89:79], zeros above
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // read_data[7:0], clipped[8], zeros above
);

  import gbf_pkg::*;

  localparam int DEPTH  = (FRAME_WIDTH / 8) * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  item_t             item;
  result_t           eng_res;
  result_t           out_res;
  logic              res_valid;
  logic              out_free;
  mem_cmd_t          mem_cmd;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  // unpack the input transaction
  assign item.kind       = s_tuser;
  assign item.pos_x      = s_tdata[7:0];
  assign item.pos_y      = s_tdata[13:8];
  assign item.glyph_rows = s_tdata[77:14];
  assign item.invert     = s_tdata[78];
  assign item.read_index = s_tdata[89:79];

  // output register frees when empty or being taken this cycle
  assign out_free = !m_tvalid || m_tready;

  gbf_engine #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .DEPTH        (DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .item      (item),
    .res_valid (res_valid),
    .out_free  (out_free),
    .res       (eng_res),
    .mem_cmd   (mem_cmd),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  gbf_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // result register on the master side
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && out_free) begin
      m_tvalid <= 1'b1;
      out_res  <= eng_res;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {7'd0, out_res.clipped, out_res.read_data};

endmodule

/* sim/glyph_blit_1bpp_framebuffer_tb.sv */
// self-checking testbench for glyph_blit_1bpp_framebuffer: directed and random
// draw, clear and read transactions checked against a frame store model
// depends on gbf_pkg and the glyph_blit_1bpp_framebuffer rtl
`timescale 1ns / 1ps

module glyph_blit_1bpp_framebuffer_tb;
  import gbf_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEMS_PER_PHASE = 400;

  // shadow copy of the frame store plus the queue of answers still owed
  class frame_scoreboard;
    localparam int ROW_BYTES = FRAME_WIDTH_DEF / 8;
    localparam int STORE_DEPTH = ROW_BYTES * FRAME_HEIGHT_DEF;

    logic [7:0] pixels [0:STORE_DEPTH-1];
    result_t    owed_answers [$];
    int         failures;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      failures = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      failures++;
    endtask

    function void merge(int addr, logic [7:0] keep, logic [7:0] bits);
      if (addr < STORE_DEPTH) pixels[addr] = (pixels[addr] & keep) | bits;
    endfunction

    // applies one transaction to the shadow store and returns its answer
    function result_t blit_answer(item_t it);
      result_t    res;
      logic [7:0] row;
      logic [7:0] lo_mask;
      logic [7:0] hi_mask;
      int         addr;
      int         sh;
      res = '0;
      case (it.kind)
        KIND_DRAW: begin
          if (int'(it.pos_x) + GLYPH_SIZE >= FRAME_WIDTH_DEF ||
              int'(it.pos_y) + GLYPH_SIZE >= FRAME_HEIGHT_DEF) begin
            res.clipped = 1'b1;
          end else begin
            addr = int'(it.pos_y) * ROW_BYTES + int'(it.pos_x) / 8;
            sh = int'(it.pos_x[2:0]);
            for (int r = 0; r < GLYPH_SIZE; r++) begin
              row = it.glyph_rows[63 - 8 * r -: 8];
              if (it.invert) row = ~row;
              lo_mask = BYTE_MASK >> sh;
              merge(addr, ~lo_mask, row >> sh);
              if (sh != 0) begin
                hi_mask = BYTE_MASK << (8 - sh);
                merge(addr + 1, ~hi_mask, row << (8 - sh));
              end
              addr += ROW_BYTES;
            end
          end
        end
        KIND_CLEAR: begin
          foreach (pixels[i]) pixels[i] = '0;
        end
        KIND_READ: begin
          if (int'(it.read_index) < STORE_DEPTH) res.read_data = pixels[it.read_index];
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_item(item_t it);
      owed_answers.push_back(blit_answer(it));
    endfunction

    task check_result(result_t got);
      result_t want;
      if (owed_answers.size() == 0) begin
        report($sformatf("result %h with no transaction outstanding", got));
      end else begin
        want = owed_answers.pop_front();
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
        if (got.clipped !== want.clipped)
          report($sformatf("clipped %b, expected %b", got.clipped, want.clipped));
      end
    endtask

    function int pending();
      return owed_answers.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  frame_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  logic [7:0] last_x = '0;
  logic [5:0] last_y = '0;

  glyph_blit_1bpp_framebuffer dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: random backpressure at the current idle rate
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // m_tdata carries read_data in the low byte and clipped above it
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(result_t'({m_tdata[7:0], m_tdata[8]}));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic item_t make_item(logic [1:0] kind, logic [7:0] x, logic [5:0] y,
                                      logic [63:0] rows, logic inv, logic [10:0] ridx);
    item_t it;
    it.kind = kind;
    it.pos_x = x;
    it.pos_y = y;
    it.glyph_rows = rows;
    it.invert = inv;
    it.read_index = ridx;
    return it;
  endfunction

  task automatic send_item(item_t it);
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, it.read_index, it.invert, it.glyph_rows, it.pos_y, it.pos_x};
    s_tuser  <= it.kind;
    do @(posedge clk); while (!s_tready);
    sb.note_item(it);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    item_t      it;
    int         pick;
    logic [7:0] x;
    logic [5:0] y;
    logic [10:0] ridx;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, aligned and shifted draws, both clipping edges,
    // unused kind, overwrite of a glyph window, clear and the last byte
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'd0));
    send_item(make_item(KIND_DRAW, 8'd0, 6'd0, 64'h8142241818244281, 1'b0, 11'd0));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'd0));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'd32));
    send_item(make_item(KIND_DRAW, 8'd247, 6'd55, 64'h0123456789abcdef, 1'b1, 11'h7ff));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(55 * 32 + 30)));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(55 * 32 + 31)));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(62 * 32 + 31)));
    send_item(make_item(KIND_DRAW, 8'd248, 6'd0, '1, 1'b0, 11'd0));
    send_item(make_item(KIND_DRAW, 8'd0, 6'd56, '1, 1'b1, 11'd0));
    send_item(make_item(KIND_DRAW, 8'd255, 6'd63, '1, 1'b0, 11'd0));
    send_item(make_item(KIND_UNUSED, 8'hff, 6'h3f, '1, 1'b1, 11'h7ff));
    send_item(make_item(KIND_DRAW, 8'd3, 6'd10, '1, 1'b0, 11'd0));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(10 * 32)));
    send_item(make_item(KIND_DRAW, 8'd5, 6'd10, 64'h00ff00ff00ff00ff, 1'b1, 11'd0));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(10 * 32)));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(11 * 32 + 1)));
    send_item(make_item(KIND_CLEAR, 8'd0, 6'd0, '1, 1'b1, 11'h7ff));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(10 * 32)));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'(55 * 32 + 31)));
    send_item(make_item(KIND_READ, 8'd0, 6'd0, '0, 1'b0, 11'h7ff));
    wait_drained();

    // random: mostly in-range draws with readback near the latest glyph
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 71 : 0;
      rx_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 34 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        it = make_item(KIND_READ, 8'($urandom), 6'($urandom), {$urandom, $urandom},
                       1'($urandom), 11'($urandom));
        if (pick < 55) begin
          x = 8'($urandom_range(0, 247));
          y = 6'($urandom_range(0, 55));
          it.kind = KIND_DRAW;
          it.pos_x = x;
          it.pos_y = y;
          last_x = x;
          last_y = y;
        end else if (pick < 85) begin
          if ($urandom_range(0, 1) == 0) begin
            ridx = 11'((int'(last_y) + $urandom_range(0, 7)) * 32 + int'(last_x) / 8
                       + $urandom_range(0, 1));
            it.read_index = ridx;
          end
        end else if (pick < 93) begin
          it.kind = KIND_DRAW;
          if ($urandom_range(0, 1) == 0) begin
            it.pos_x = 8'($urandom_range(248, 255));
          end else begin
            it.pos_y = 6'($urandom_range(56, 63));
          end
        end else if (pick < 97) begin
          it.kind = KIND_UNUSED;
        end else begin
          it.kind = KIND_CLEAR;
        end
        send_item(it);
        // occasionally hold off until the block has answered everything
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* glyph_blit_1bpp_framebuffer.f */
rtl/gbf_pkg.sv
rtl/gbf_store.sv
rtl/gbf_engine.sv
rtl/glyph_blit_1bpp_framebuffer.sv
sim/glyph_blit_1bpp_framebuffer_tb.sv
